// ===== rtl/tans_encoder_step_defines.svh =====
// ----------------------------------------------------------------------------
// tans_encoder_step_defines.svh
// Assertion macros shared by the tANS encoder step RTL.
// ----------------------------------------------------------------------------
`ifndef TANS_ENCODER_STEP_DEFINES_SVH
`define TANS_ENCODER_STEP_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define TANS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define TANS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tans_pkg.sv =====
// ----------------------------------------------------------------------------
// tans_pkg
// Types and constants of the tANS encoder step: item layouts, op codes,
// chunk kinds and the back-end sequencer states.
// ----------------------------------------------------------------------------
package tans_pkg;

   localparam int TABLE_W   = 2;
   localparam int SYM_W     = 6;
   localparam int SLOT_W    = 10;
   localparam int STATE_W   = 11;
   localparam int SHIFT_W   = 4;
   localparam int LOG_W     = 4;
   localparam int LEN_W     = 4;
   localparam int OFFSET_W  = 16;
   localparam int COUNT_W   = 7;
   localparam int SYMBOL_W  = 24;
   localparam int VALUE_W   = SYMBOL_W + 1;
   localparam int RAW_W     = 25;
   localparam int ADDR_W    = TABLE_W + SYM_W + SLOT_W;
   localparam int ENTRY_W   = SHIFT_W + STATE_W;
   localparam int MAX_LOG   = 10;
   localparam int MAX_SYMS  = 64;
   localparam int CMD_DEPTH = 2;

   localparam logic [LOG_W-1:0]   RESET_LOG   = LOG_W'(10);
   localparam logic [STATE_W-1:0] RESET_STATE = STATE_W'(1) << RESET_LOG;

   typedef enum logic [1:0] {
      OP_LOAD_CODE   = 2'd0,
      OP_LOAD_HEADER = 2'd1,
      OP_ENCODE      = 2'd2,
      OP_FINISH      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_MAIN   = 2'd0,
      KIND_BYPASS = 2'd1,
      KIND_FINAL  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_ESC_RUN,
      ST_ESC_NIB
   } back_state_type;

   typedef struct packed {
      op_type                       operation;
      logic [TABLE_W-1:0]           table_index;
      logic [SYM_W-1:0]             symbol_slot;
      logic [SLOT_W-1:0]            state_slot;
      logic [SHIFT_W-1:0]           entry_shift;
      logic [STATE_W-1:0]           entry_next_state;
      logic signed [OFFSET_W-1:0]   header_offset;
      logic [COUNT_W-1:0]           header_count;
      logic signed [SYMBOL_W-1:0]   symbol_value;
   } req_type;

   typedef struct packed {
      kind_type             chunk_kind;
      logic [STATE_W-1:0]   chunk_bits;
      logic [LEN_W-1:0]     chunk_length;
      logic                 last;
   } rsp_type;

   // classified work for the back end; header loads never get here
   typedef struct packed {
      op_type               op;
      logic [TABLE_W-1:0]   table_index;
      logic [SYM_W-1:0]     sym;
      logic [SLOT_W-1:0]    slot;
      logic [ENTRY_W-1:0]   entry;
      logic                 esc;
      logic [RAW_W-1:0]     raw;
   } cmd_type;

endpackage

// ===== rtl/tans_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// tans_cmd_fifo
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module tans_cmd_fifo
   import tans_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output cmd_type rd_data,
   output logic    empty
);

   localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type            slots_ff [CMD_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMD_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_wr && !do_rd) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_rd && !do_wr) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/tans_front.sv =====
// ----------------------------------------------------------------------------
// tans_front
// Accepts items, applies header loads, maps symbols into their table and
// detects escapes, then hands commands to the back end.
// ----------------------------------------------------------------------------
module tans_front
   import tans_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_item,
   output logic    cmd_push,
   input  logic    cmd_full,
   output cmd_type cmd_data,
   output logic    busy
);

   // per-table header, count kept as the escape symbol index
   logic signed [OFFSET_W-1:0] hdr_offset_ff [1 << TABLE_W];
   logic [SYM_W-1:0]           hdr_maxv_ff   [1 << TABLE_W];

   // stage 1 registers
   logic                  s1_valid_ff, s1_valid_in;
   op_type                s1_op_ff;
   logic [TABLE_W-1:0]    s1_table_ff;
   logic [SYM_W-1:0]      s1_sym_ff;
   logic [SLOT_W-1:0]     s1_slot_ff;
   logic [ENTRY_W-1:0]    s1_entry_ff;
   logic [VALUE_W-1:0]    s1_value_ff, s1_value_in;
   logic [SYM_W-1:0]      s1_maxv_ff;

   logic                  accept, advance, load_hdr;
   logic [SYM_W-1:0]      maxv_in;
   logic [VALUE_W:0]      diff;
   logic                  neg, above, esc;
   logic [RAW_W-1:0]      raw;

   assign advance  = s1_valid_ff && !cmd_full;
   assign full     = s1_valid_ff && cmd_full;
   assign accept   = push && !full;
   assign load_hdr = accept && (req_item.operation == OP_LOAD_HEADER);
   assign busy     = s1_valid_ff;

   // clamp count into 1..MAX_SYMS, keep count-1
   always_comb begin
      if (req_item.header_count == '0) begin
         maxv_in = '0;
      end else if (req_item.header_count > COUNT_W'(MAX_SYMS)) begin
         maxv_in = SYM_W'(MAX_SYMS - 1);
      end else begin
         maxv_in = SYM_W'(req_item.header_count - 1'b1);
      end
   end

   assign s1_value_in = {req_item.symbol_value[SYMBOL_W-1], req_item.symbol_value}
      - {{(VALUE_W - OFFSET_W){hdr_offset_ff[req_item.table_index][OFFSET_W-1]}},
         hdr_offset_ff[req_item.table_index]};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (accept && !load_hdr) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_hdr) begin
         hdr_offset_ff[req_item.table_index] <= req_item.header_offset;
         hdr_maxv_ff[req_item.table_index]   <= maxv_in;
      end
      if (accept && !load_hdr) begin
         s1_op_ff    <= req_item.operation;
         s1_table_ff <= req_item.table_index;
         s1_sym_ff   <= req_item.symbol_slot;
         s1_slot_ff  <= req_item.state_slot;
         s1_entry_ff <= {req_item.entry_shift, req_item.entry_next_state};
         s1_value_ff <= s1_value_in;
         s1_maxv_ff  <= hdr_maxv_ff[req_item.table_index];
      end
   end

   // stage 2: range check and zigzag fold
   assign diff  = {s1_value_ff[VALUE_W-1], s1_value_ff} - {{(VALUE_W + 1 - SYM_W){1'b0}}, s1_maxv_ff};
   assign neg   = s1_value_ff[VALUE_W-1];
   assign above = !diff[VALUE_W];
   assign esc   = neg || above;

   always_comb begin
      if (neg) begin
         raw = ~{s1_value_ff[RAW_W-2:0], 1'b0};
      end else if (above) begin
         raw = {diff[RAW_W-2:0], 1'b0};
      end else begin
         raw = '0;
      end
   end

   always_comb begin
      cmd_data.op          = s1_op_ff;
      cmd_data.table_index = s1_table_ff;
      cmd_data.slot        = s1_slot_ff;
      cmd_data.entry       = s1_entry_ff;
      cmd_data.esc         = 1'b0;
      cmd_data.raw         = raw;
      cmd_data.sym         = s1_sym_ff;
      if (s1_op_ff == OP_ENCODE) begin
         cmd_data.esc = esc;
         cmd_data.sym = esc ? s1_maxv_ff : s1_value_ff[SYM_W-1:0];
      end
   end

   assign cmd_push = s1_valid_ff;

endmodule

// ===== rtl/tans_back.sv =====
// ----------------------------------------------------------------------------
// tans_back
// Code table memory, coder state and chunk sequencer with result register.
// ----------------------------------------------------------------------------
module tans_back
   import tans_pkg::*;
#(
   parameter int NIBBLE_BITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [LOG_W-1:0] table_log,
   input  cmd_type          cmd_data,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output rsp_type          rsp_item
);

   localparam int MAXN = (RAW_W + NIBBLE_BITS - 1) / NIBBLE_BITS;
   localparam int NW   = $clog2(MAXN + 1);
   localparam int CW   = (NW > NIBBLE_BITS) ? NW : NIBBLE_BITS;
   localparam logic [CW-1:0] MAXB = CW'((1 << NIBBLE_BITS) - 1);

   logic [ENTRY_W-1:0] code_mem [1 << ADDR_W];
   logic [ENTRY_W-1:0] rd_data_ff;

   back_state_type     state_ff, state_in;
   logic [STATE_W-1:0] coder_ff, coder_in;
   cmd_type            cmd_ff, cmd_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      rem_ff, rem_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [RAW_W-1:0]   raw_ff, raw_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   logic               out_free;
   logic [LOG_W-1:0]   lg;
   logic [SLOT_W-1:0]  slot_mask;
   logic [STATE_W-1:0] l_value;
   logic [SHIFT_W-1:0] shift;
   logic [STATE_W:0]   shift_mask;
   logic [NW-1:0]      nib_count;
   logic [NW-1:0]      cnt_next;

   assign out_free = !out_valid_ff || pop;
   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

   // table_log clamped into 1..MAX_LOG
   always_comb begin
      if (table_log == '0) begin
         lg = LOG_W'(1);
      end else if (table_log > LOG_W'(MAX_LOG)) begin
         lg = LOG_W'(MAX_LOG);
      end else begin
         lg = table_log;
      end
   end

   assign l_value   = STATE_W'(1) << lg;
   assign slot_mask = SLOT_W'(l_value - 1'b1);

   assign shift      = (rd_data_ff[ENTRY_W-1 -: SHIFT_W] > SHIFT_W'(STATE_W))
                       ? SHIFT_W'(STATE_W) : rd_data_ff[ENTRY_W-1 -: SHIFT_W];
   assign shift_mask = (STATE_W + 1)'(1) << shift;

   // nibbles in raw: groups above each nibble boundary that are nonzero
   always_comb begin
      nib_count = '0;
      for (int k = 0; k < MAXN; k++) begin
         nib_count = NW'(nib_count + NW'((cmd_ff.raw >> (k * NIBBLE_BITS)) != '0));
      end
   end

   assign cnt_next = NW'(cnt_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      coder_in     = coder_ff;
      cmd_in       = cmd_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      raw_in       = raw_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = {cmd_data.table_index, cmd_data.sym, cmd_data.slot};

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               case (cmd_data.op)
                  OP_LOAD_CODE: begin
                     cmd_pop = 1'b1;
                     mem_we  = 1'b1;
                  end
                  OP_ENCODE: begin
                     cmd_pop  = 1'b1;
                     mem_re   = 1'b1;
                     mem_addr = {cmd_data.table_index, cmd_data.sym,
                                 coder_ff[SLOT_W-1:0] & slot_mask};
                     cmd_in   = cmd_data;
                     state_in = ST_LOOKUP;
                  end
                  OP_FINISH: begin
                     if (out_free) begin
                        cmd_pop             = 1'b1;
                        out_valid_in        = 1'b1;
                        out_in.chunk_kind   = KIND_FINAL;
                        out_in.chunk_bits   = coder_ff;
                        out_in.chunk_length = LEN_W'(STATE_W);
                        out_in.last         = 1'b1;
                        coder_in            = l_value;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (shift == '0 || out_free) begin
               if (shift != '0) begin
                  out_valid_in        = 1'b1;
                  out_in.chunk_kind   = KIND_MAIN;
                  out_in.chunk_bits   = coder_ff & shift_mask[STATE_W-1:0] - 1'b1;
                  out_in.chunk_length = LEN_W'(shift);
                  out_in.last         = !cmd_ff.esc;
               end
               coder_in = rd_data_ff[STATE_W-1:0];
               n_in     = nib_count;
               rem_in   = nib_count;
               raw_in   = cmd_ff.raw;
               cnt_in   = '0;
               state_in = cmd_ff.esc ? ST_ESC_RUN : ST_IDLE;
            end
         end
         ST_ESC_RUN: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.chunk_kind   = KIND_BYPASS;
               out_in.chunk_length = LEN_W'(NIBBLE_BITS);
               if (CW'(rem_ff) >= MAXB) begin
                  out_in.chunk_bits = STATE_W'(MAXB);
                  out_in.last       = 1'b0;
                  rem_in            = NW'(CW'(rem_ff) - MAXB);
               end else begin
                  out_in.chunk_bits = STATE_W'(rem_ff);
                  out_in.last       = (n_ff == '0);
                  state_in          = (n_ff == '0) ? ST_IDLE : ST_ESC_NIB;
               end
            end
         end
         ST_ESC_NIB: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.chunk_kind   = KIND_BYPASS;
               out_in.chunk_bits   = STATE_W'(raw_ff[NIBBLE_BITS-1:0]);
               out_in.chunk_length = LEN_W'(NIBBLE_BITS);
               out_in.last         = (cnt_next == n_ff);
               raw_in              = raw_ff >> NIBBLE_BITS;
               cnt_in              = cnt_next;
               if (cnt_next == n_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         coder_ff     <= RESET_STATE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coder_ff     <= coder_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      n_ff   <= n_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      raw_ff <= raw_in;
      out_ff <= out_in;
   end

   // single-port code table, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         code_mem[mem_addr] <= cmd_data.entry;
      end
      if (mem_re) begin
         rd_data_ff <= code_mem[mem_addr];
      end
   end

endmodule

// ===== rtl/tans_encoder_step.sv =====
// ----------------------------------------------------------------------------
// tans_encoder_step
// Table-based ANS encoder step over four code tables held in memory.
//
//  channel | ports                                   | beat accepted when
//  --------+-----------------------------------------+--------------------
//  request | push, full, req_item                    | push && !full
//  result  | empty, pop, rsp_item                    | pop && !empty
//  config  | csr_write_enable, csr_write_data        | csr_write_enable
//
// Front end takes one beat a cycle into a one-deep stage while the queue has
// room; header loads end there. Back end, after the command queue: code load
// and finish act from idle; encode reads the code table, updates the state and
// sends any bypass chunks, paced by the single memory port and one-deep result register.
// Synchronous reset clears control and sets the coder state to 1024; the
// code table and headers are not cleared. Either side may stall freely.
// ----------------------------------------------------------------------------
`include "tans_encoder_step_defines.svh"

module tans_encoder_step
   import tans_pkg::*;
#(
   parameter int NIBBLE_BITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  req_type          req_item,
   output logic             empty,
   input  logic             pop,
   output rsp_type          rsp_item,
   input  logic             csr_write_enable,
   input  logic [LOG_W-1:0] csr_write_data
);

   logic [LOG_W-1:0] table_log_ff;
   logic [LOG_W-1:0] table_log_in;
   logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
   cmd_type          cmd_wr, cmd_rd;
   logic             front_busy;

   assign table_log_in = csr_write_enable ? csr_write_data : table_log_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_log_ff <= RESET_LOG;
      end else begin
         table_log_ff <= table_log_in;
      end
   end

   tans_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .cmd_push (cmd_push),
      .cmd_full (cmd_full),
      .cmd_data (cmd_wr),
      .busy     (front_busy)
   );

   tans_cmd_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   tans_back #(
      .NIBBLE_BITS (NIBBLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .table_log (table_log_ff),
      .cmd_data  (cmd_rd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item)
   );

   `TANS_ASSERT_IMP(a_full_from_queue, full, cmd_full, "front stalled without a full queue")
   `TANS_ASSERT_NXT(a_item_held, push && !full && req_item.operation != OP_LOAD_HEADER, front_busy, "accepted item lost in front end")
   `TANS_ASSERT_IMP(a_final_last, !empty && rsp_item.chunk_kind == KIND_FINAL, rsp_item.last && rsp_item.chunk_length == LEN_W'(STATE_W), "final state chunk malformed")
   `TANS_ASSERT_IMP(a_main_len, !empty && rsp_item.chunk_kind == KIND_MAIN, rsp_item.chunk_length != '0 && rsp_item.chunk_length <= LEN_W'(STATE_W), "main chunk length out of range")

endmodule

// ===== test/tans_encoder_step_tb.sv =====
// ----------------------------------------------------------------------------
// tans_encoder_step_tb
// Self-checking bench for the tANS encoder step. Code entries are loaded
// on demand so that every encode reads written memory. Each accepted
// beat is run through a local predictor, and every result beat is checked
// against the oldest predicted chunk. Both sides idle at random, and the
// table_log register is swept between phases.
// ----------------------------------------------------------------------------
module tans_encoder_step_tb
   import tans_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRY_COUNT = 4 * 64 * 1024;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             push             = 1'b0;
   logic             full;
   req_type          req_item         = '0;
   logic             empty;
   logic             pop              = 1'b0;
   rsp_type          rsp_item;
   logic             csr_write_enable = 1'b0;
   logic [LOG_W-1:0] csr_write_data   = '0;

   // predictor state
   logic [STATE_W-1:0] predicted_state = 11'd1024;
   logic [LOG_W-1:0]   log_setting     = 4'd10;
   logic [14:0]        entry_store  [ENTRY_COUNT];
   bit                 entry_loaded [ENTRY_COUNT];
   int                 sym_offset [4];
   int unsigned        table_size [4];
   rsp_type            pending_chunks [$];

   int unsigned mismatches   = 0;
   int unsigned items_sent   = 0;
   int unsigned req_idle_max = 10;
   int unsigned rsp_idle_max = 10;

   always #10 clock = ~clock;

   tans_encoder_step u_top (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_item         (req_item),
      .empty            (empty),
      .pop              (pop),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   function automatic int unsigned active_log();
      int unsigned lg;
      lg = log_setting;
      if (lg < 1) lg = 1;
      if (lg > MAX_LOG) lg = MAX_LOG;
      return lg;
   endfunction

   function automatic int unsigned slot_of(input logic [STATE_W-1:0] st);
      return int'(st) & ((1 << active_log()) - 1);
   endfunction

   function automatic int unsigned code_addr(input int unsigned t, idx, slot);
      return (t * 64 + idx) * 1024 + slot;
   endfunction

   function automatic int capped_count(input int t);
      int c;
      c = table_size[t];
      if (c == 0) c = 1;
      if (c > MAX_SYMS) c = MAX_SYMS;
      return c;
   endfunction

   // symbol index the table lookup uses; out-of-range values go to escape
   function automatic void map_symbol(input int t, input logic [SYMBOL_W-1:0] sym,
                                      output int unsigned idx, output logic esc,
                                      output logic [RAW_W-1:0] raw);
      int top;
      int value;
      top   = capped_count(t) - 1;
      value = int'($signed(sym)) - sym_offset[t];
      esc   = 1'b1;
      idx   = top;
      raw   = '0;
      if (value < 0) raw = RAW_W'(-2 * value - 1);
      else if (value >= top) raw = RAW_W'(2 * (value - top));
      else begin
         esc = 1'b0;
         idx = value;
      end
   endfunction

   function automatic void add_chunk(input kind_type kind, input int unsigned bits,
                                     input int unsigned len);
      rsp_type c;
      c.chunk_kind   = kind;
      c.chunk_bits   = bits[STATE_W-1:0];
      c.chunk_length = len[LEN_W-1:0];
      c.last         = 1'b0;
      pending_chunks = {pending_chunks, c};
   endfunction

   function automatic void predict_chunks(input req_type beat);
      int unsigned t, idx, addr, shift, nibs, rest, before_size;
      logic esc;
      logic [RAW_W-1:0] raw, tmp;
      logic [14:0] entry;
      rsp_type tail;
      t = beat.table_index;
      before_size = pending_chunks.size();
      case (beat.operation)
         OP_LOAD_CODE: begin
            addr = code_addr(t, beat.symbol_slot, beat.state_slot);
            entry_store[addr]  = {beat.entry_shift, beat.entry_next_state};
            entry_loaded[addr] = 1'b1;
         end
         OP_LOAD_HEADER: begin
            sym_offset[t] = int'($signed(beat.header_offset));
            table_size[t] = beat.header_count;
         end
         OP_FINISH: begin
            add_chunk(KIND_FINAL, predicted_state, STATE_W);
            predicted_state = STATE_W'(1 << active_log());
         end
         default: begin
            map_symbol(t, beat.symbol_value, idx, esc, raw);
            entry = entry_store[code_addr(t, idx, slot_of(predicted_state))];
            shift = entry[14:11];
            if (shift > STATE_W) shift = STATE_W;
            if (shift != 0)
               add_chunk(KIND_MAIN, int'(predicted_state) & ((1 << shift) - 1), shift);
            predicted_state = entry[10:0];
            if (esc) begin
               nibs = 0;
               for (tmp = raw; tmp != 0; tmp = tmp >> 4) nibs++;
               rest = nibs;
               while (rest >= 15) begin
                  add_chunk(KIND_BYPASS, 15, 4);
                  rest -= 15;
               end
               add_chunk(KIND_BYPASS, rest, 4);
               for (int j = 0; j < nibs; j++)
                  add_chunk(KIND_BYPASS, (raw >> (4 * j)) & 25'hF, 4);
            end
         end
      endcase
      if (pending_chunks.size() > before_size) begin
         tail = pending_chunks.pop_back();
         tail.last = 1'b1;
         pending_chunks = {pending_chunks, tail};
      end
   endfunction

   function automatic req_type random_beat();
      logic [95:0] r;
      r = {$urandom, $urandom, $urandom};
      return r[$bits(req_type)-1:0];
   endfunction

   function automatic int rand_shift();
      if ($urandom_range(0, 99) < 80) return $urandom_range(0, active_log());
      return $urandom_range(0, 15);
   endfunction

   function automatic int rand_next_state();
      int unsigned size;
      size = 1 << active_log();
      if ($urandom_range(0, 99) < 70) return size + $urandom_range(0, size - 1);
      return $urandom_range(0, 2047);
   endfunction

   function automatic int pick_symbol(input int t);
      int top, k;
      top = capped_count(t) - 1;
      k   = $urandom_range(0, 99);
      if (k < 65 && top > 0) return sym_offset[t] + int'($urandom_range(0, top - 1));
      if (k < 75) return sym_offset[t] + top + int'($urandom_range(0, 20));
      if (k < 85) return sym_offset[t] - int'($urandom_range(1, 300));
      return int'($urandom);
   endfunction

   task automatic send_item(input req_type beat);
      int unsigned gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= beat;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_chunks(beat);
      items_sent++;
   endtask

   task automatic load_code(input int t, idx, slot, shift, nxt);
      req_type beat;
      beat = random_beat();
      beat.operation        = OP_LOAD_CODE;
      beat.table_index      = t[1:0];
      beat.symbol_slot      = idx[5:0];
      beat.state_slot       = slot[9:0];
      beat.entry_shift      = shift[3:0];
      beat.entry_next_state = nxt[10:0];
      send_item(beat);
   endtask

   task automatic load_header(input int t, off, cnt);
      req_type beat;
      beat = random_beat();
      beat.operation     = OP_LOAD_HEADER;
      beat.table_index   = t[1:0];
      beat.header_offset = off[15:0];
      beat.header_count  = cnt[6:0];
      send_item(beat);
   endtask

   // loads the entry the encode will read first, if forced or never written
   task automatic encode(input int t, sym, input bit reload, input int shift, nxt);
      int unsigned idx, slot;
      logic esc;
      logic [RAW_W-1:0] raw;
      req_type beat;
      map_symbol(t, sym[23:0], idx, esc, raw);
      slot = slot_of(predicted_state);
      if (reload || !entry_loaded[code_addr(t, idx, slot)])
         load_code(t, idx, slot, shift, nxt);
      beat = random_beat();
      beat.operation    = OP_ENCODE;
      beat.table_index  = t[1:0];
      beat.symbol_value = sym[23:0];
      send_item(beat);
   endtask

   task automatic finish_stream();
      req_type beat;
      beat = random_beat();
      beat.operation = OP_FINISH;
      send_item(beat);
   endtask

   // wait out the loads still in the pipe once all results are back
   task automatic drain();
      push <= 1'b0;
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_table_log(input logic [LOG_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      log_setting = v;
   endtask

   task automatic test_reset_state();
      finish_stream();
   endtask

   task automatic test_header_limits();
      load_header(0, 0, 16);
      load_header(1, -32768, 64);
      load_header(2, 32767, 1);
      load_header(3, -5, 0);
   endtask

   task automatic test_encode_cases();
      encode(0, 3, 1, 10, 1029);              // in range, wide main chunk
      encode(0, 0, 1, 0, 2047);               // no output at all
      encode(0, 15, 1, 15, 0);                // escape of zero, shift saturates
      encode(0, -1, 1, 11, 1500);             // below offset, from state zero
      encode(1, 8388607, 1, 4, 1030);         // largest symbol, seven nibbles
      encode(2, -8388608, 1, 1, 1024);        // smallest symbol, escape-only table
      encode(3, 100, 1, 2, 1100);             // zero count acts as one
      load_header(3, -5, 127);                // count above the cap
      encode(3, 30, 1, 3, 1024);
      encode(1, -32768 + 63, 1, 5, 2000);     // symbol slot 63
      finish_stream();
   endtask

   task automatic run_random_phase(input logic [LOG_W-1:0] log_value,
                                   input int unsigned req_idle, rsp_idle, beats);
      int unsigned stop_at, pick, t;
      drain();
      write_table_log(log_value);
      req_idle_max = req_idle;
      rsp_idle_max = rsp_idle;
      stop_at = items_sent + beats;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         t    = $urandom_range(0, 3);
         if (pick < 4) begin
            if ($urandom_range(0, 1) != 0) load_header(t, $urandom, $urandom_range(0, 127));
            else load_header(t, int'($urandom_range(0, 200)) - 100, $urandom_range(0, 127));
         end else if (pick < 8) begin
            load_code(t, $urandom_range(0, 63), $urandom_range(0, 1023),
                      rand_shift(), rand_next_state());
         end else if (pick < 14) begin
            finish_stream();
         end else begin
            encode(t, pick_symbol(t), $urandom_range(0, 99) < 10,
                   rand_shift(), rand_next_state());
         end
      end
   endtask

   task automatic test_table_log_sweep();
      run_random_phase(4'd1, 10, 10, 48);
      run_random_phase(4'd0, 0, 0, 48);       // clamps up to one
      run_random_phase(4'd15, 10, 0, 48);     // clamps down to ten
      run_random_phase(4'd5, 0, 10, 48);
      run_random_phase(4'd3, 10, 10, 48);
      run_random_phase(4'd10, 3, 3, 48);
   endtask

   function automatic void compare_field(input string name,
                                         input logic [STATE_W-1:0] want, got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   initial begin : result_checker
      int unsigned gap;
      rsp_type want;
      wait (reset == 1'b0);
      forever begin
         gap = $urandom_range(0, rsp_idle_max);
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (pending_chunks.size() == 0) begin
            $display("%0t ns: unexpected chunk kind %0d bits %0d length %0d last %0d",
                     $time, rsp_item.chunk_kind, rsp_item.chunk_bits,
                     rsp_item.chunk_length, rsp_item.last);
            mismatches++;
         end else begin
            want = pending_chunks.pop_front();
            compare_field("chunk_kind", want.chunk_kind, rsp_item.chunk_kind);
            compare_field("chunk_bits", want.chunk_bits, rsp_item.chunk_bits);
            compare_field("chunk_length", want.chunk_length, rsp_item.chunk_length);
            compare_field("last", want.last, rsp_item.last);
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_header_limits();
      test_encode_cases();
      test_table_log_sweep();
      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("tans_encoder_step_tb: done, clean");
      end else begin
         $display("tans_encoder_step_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tans_encoder_step_tb: done, errors");
      $finish;
   end

endmodule
